### hdl/cspd_pkg.sv
`timescale 1ns / 1ps

package cspd_pkg;

  localparam int unsigned TimeW      = 32;
  localparam int unsigned DistW      = 32;
  localparam int unsigned CadW       = 8;
  localparam int unsigned SpdW       = 16;
  localparam int unsigned DelaySW    = 6;
  localparam int unsigned LimitW     = 4;
  localparam int unsigned DelayMsW   = 16;  // 63 s * 1000 fits
  localparam int unsigned LimitCkphW = 11;  // 15 km/h * 100 fits
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 6;
  localparam int unsigned InDataW    = 88;
  localparam int unsigned OutDataW   = 128;

  localparam logic [DelaySW-1:0] DefaultRestS    = 6'd10;
  localparam logic [DelaySW-1:0] DefaultStandbyS = 6'd5;
  localparam logic [LimitW-1:0]  DefaultLimitKph = 4'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REST_DELAY    = 2'd0,
    REG_STANDBY_DELAY = 2'd1,
    REG_STANDBY_LIMIT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KIND_STOP  = 1'b0,
    KIND_COAST = 1'b1
  } period_kind_e;

  typedef struct packed {
    logic [DelayMsW-1:0]   rest_ms;
    logic [DelayMsW-1:0]   stby_ms;
    logic [LimitCkphW-1:0] limit_ckph;
  } cfg_t;

  typedef struct packed {
    logic [SpdW-1:0]  speed_ckph;
    logic [CadW-1:0]  cadence_rpm;
    logic [DistW-1:0] distance_m;
    logic [TimeW-1:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic [DistW-1:0] end_distance_m;
    logic [TimeW-1:0] end_time_ms;
    logic [DistW-1:0] start_distance_m;
    logic [TimeW-1:0] start_time_ms;
  } period_t;

  function automatic logic [DelayMsW-1:0] sec_to_ms(logic [DelaySW-1:0] s,
                                                     logic [DelaySW-1:0] dflt);
    logic [DelaySW-1:0] eff;
    eff = (s == '0) ? dflt : s;
    return DelayMsW'(DelayMsW'(eff) * DelayMsW'(1000));
  endfunction

  function automatic logic [LimitCkphW-1:0] kph_to_ckph(logic [LimitW-1:0] k);
    logic [LimitW-1:0] eff;
    eff = (k == '0) ? DefaultLimitKph : k;
    return LimitCkphW'(LimitCkphW'(eff) * LimitCkphW'(100));
  endfunction

  // now - start > delay, with a backwards step counting as no time at all
  function automatic logic elapsed_over(logic [TimeW-1:0] now, logic [TimeW-1:0] start,
                                        logic [DelayMsW-1:0] delay);
    logic [TimeW:0] diff;
    diff = {1'b0, now} - {1'b0, start};
    return !diff[TimeW] && (diff[TimeW-1:0] > TimeW'(delay));
  endfunction

endpackage

### hdl/cspd_cfg.sv
`timescale 1ns / 1ps

module cspd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cspd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cspd_pkg::CfgDataW-1:0] cfg_data_i,
  output cspd_pkg::cfg_t                cfg_o
);
  import cspd_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  // registers are kept already scaled to ms and 0.01 km/h
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_REST_DELAY:    cfg_d.rest_ms    = sec_to_ms(cfg_data_i, DefaultRestS);
        REG_STANDBY_DELAY: cfg_d.stby_ms    = sec_to_ms(cfg_data_i, DefaultStandbyS);
        REG_STANDBY_LIMIT: cfg_d.limit_ckph = kph_to_ckph(cfg_data_i[LimitW-1:0]);
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rest_ms    <= sec_to_ms('0, DefaultRestS);
      cfg_q.stby_ms    <= sec_to_ms('0, DefaultStandbyS);
      cfg_q.limit_ckph <= kph_to_ckph('0);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/coast_and_stop_period_detector.sv
`timescale 1ns / 1ps

// Coast and stop period detector. Takes one ride sample per cycle and emits at
// most one period per sample: a stop period (tuser 0) when speed rises above
// the standby limit after being at or below it for longer than the standby
// delay, or a coast period (tuser 1) when pedalling resumes while moving after
// more than the rest delay of zero cadence. Each sample is registered, then
// evaluated against the held start points, and a period that it closes is
// written into the output register, from which it is offered.
// Sustained rate is one sample per cycle; while a period waits in the output
// register the input register holds one more sample, and the input side stalls
// only when a sample that closes a period meets a full output register that is
// not drained in the same cycle. The user is to write registers through the cfg
// channel only while no sample is in flight; the block does not enforce this.
module coast_and_stop_period_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cfg write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cspd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cspd_pkg::CfgDataW-1:0] cfg_data_i,
  // samples in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] time_ms, [63:32] distance_m, [71:64] cadence_rpm, [87:72] speed_ckph
  input  logic [cspd_pkg::InDataW-1:0]  s_axis_tdata,
  // periods out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] start_time_ms, [63:32] start_distance_m, [95:64] end_time_ms,
  // [127:96] end_distance_m
  output logic [cspd_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] period_kind
  output logic                          m_axis_tuser
);
  import cspd_pkg::*;

  cfg_t cfg;

  cspd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // input register
  logic    in_valid_q;
  sample_t in_q;

  // held period starts
  logic             coast_pend_q, coast_pend_d;
  logic [TimeW-1:0] coast_time_q, coast_time_d;
  logic [DistW-1:0] coast_dist_q, coast_dist_d;
  logic             stop_pend_q, stop_pend_d;
  logic [TimeW-1:0] stop_time_q, stop_time_d;
  logic [DistW-1:0] stop_dist_q, stop_dist_d;

  // output register
  logic         out_valid_q;
  period_t      out_q, res;
  period_kind_e out_kind_q, res_kind;

  logic moving, cad_zero, stop_hit, coast_hit, emit, advance;

  assign moving   = in_q.speed_ckph > SpdW'(cfg.limit_ckph);
  assign cad_zero = (in_q.cadence_rpm == '0);

  // a stop start is only taken while not moving, so on a moving sample the
  // held start is the one to check; same for coast with nonzero cadence
  assign stop_hit  = moving && stop_pend_q &&
                     elapsed_over(in_q.time_ms, stop_time_q, cfg.stby_ms);
  assign coast_hit = !cad_zero && moving && coast_pend_q &&
                     elapsed_over(in_q.time_ms, coast_time_q, cfg.rest_ms);
  assign emit      = stop_hit || coast_hit;

  assign advance       = in_valid_q && (!emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    res.end_time_ms     = in_q.time_ms;
    res.end_distance_m  = in_q.distance_m;
    if (stop_hit) begin
      res_kind             = KIND_STOP;
      res.start_time_ms    = stop_time_q;
      res.start_distance_m = stop_dist_q;
    end else begin
      res_kind             = KIND_COAST;
      res.start_time_ms    = coast_time_q;
      res.start_distance_m = coast_dist_q;
    end
  end

  always_comb begin
    coast_pend_d = coast_pend_q;
    coast_time_d = coast_time_q;
    coast_dist_d = coast_dist_q;
    stop_pend_d  = stop_pend_q;
    stop_time_d  = stop_time_q;
    stop_dist_d  = stop_dist_q;
    if (advance) begin
      if (cad_zero && moving && !coast_pend_q) begin
        coast_pend_d = 1'b1;
        coast_time_d = in_q.time_ms;
        coast_dist_d = in_q.distance_m;
      end
      if (!moving && !stop_pend_q) begin
        stop_pend_d = 1'b1;
        stop_time_d = in_q.time_ms;
        stop_dist_d = in_q.distance_m;
      end
      if (!cad_zero || !moving) begin
        coast_pend_d = 1'b0;
      end
      if (moving) begin
        stop_pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      coast_pend_q <= 1'b0;
      stop_pend_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      coast_pend_q <= coast_pend_d;
      stop_pend_q  <= stop_pend_d;
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= sample_t'(s_axis_tdata);
    end
    coast_time_q <= coast_time_d;
    coast_dist_q <= coast_dist_d;
    stop_time_q  <= stop_time_d;
    stop_dist_q  <= stop_dist_d;
    if (advance && emit) begin
      out_q      <= res;
      out_kind_q <= res_kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

### hdl/cspd_checker.sv
`timescale 1ns / 1ps

module cspd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [cspd_pkg::OutDataW-1:0] m_axis_tdata
);
  import cspd_pkg::*;

  logic [TimeW-1:0] start_t, end_t;
  logic [TimeW:0]   dur;

  assign start_t = m_axis_tdata[TimeW-1:0];
  assign end_t   = m_axis_tdata[2*TimeW+DistW-1:TimeW+DistW];
  assign dur     = {1'b0, end_t} - {1'b0, start_t};

  // a stalled period stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("period dropped while stalled");

  // a period never closes before it opened
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !dur[TimeW])
    else $error("period end precedes its start");

  // every delay is at least one second, so every period is longer than that
  a_min_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (dur[TimeW] || (dur[TimeW-1:0] > TimeW'(1000))))
    else $error("period shorter than the minimum delay");

endmodule

bind coast_and_stop_period_detector cspd_checker u_cspd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

### test/tb_coast_and_stop_period_detector.sv
`timescale 1ns / 1ps

module tb_coast_and_stop_period_detector;
  import cspd_pkg::*;

  localparam int unsigned IdleLimit     = 4000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned ItemsPerPhase = 195;
  localparam int unsigned RandomPhases  = 9;

  typedef struct packed {
    period_kind_e kind;
    period_t      span;
  } period_rec_t;

  typedef enum logic [1:0] {
    RIDE_STOPPED,
    RIDE_COASTING,
    RIDE_PEDALLING
  } ride_mode_e;

  // Tracks where a stop or a coast began and queues the periods the block owes.
  class ride_period_model;
    logic [DelaySW-1:0] rest_s;
    logic [DelaySW-1:0] stby_s;
    logic [LimitW-1:0]  limit_kph;
    bit                 coast_held;
    logic [TimeW-1:0]   coast_t0;
    logic [DistW-1:0]   coast_d0;
    bit                 stop_held;
    logic [TimeW-1:0]   stop_t0;
    logic [DistW-1:0]   stop_d0;
    period_rec_t        pending_periods[$];
    int unsigned        mismatches;

    function new();
      rest_s     = '0;
      stby_s     = '0;
      limit_kph  = '0;
      coast_held = 1'b0;
      coast_t0   = '0;
      coast_d0   = '0;
      stop_held  = 1'b0;
      stop_t0    = '0;
      stop_d0    = '0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_REST_DELAY:    rest_s = data[DelaySW-1:0];
        REG_STANDBY_DELAY: stby_s = data[DelaySW-1:0];
        REG_STANDBY_LIMIT: limit_kph = data[LimitW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned coast_delay_ms();
      return ((rest_s == 0) ? 10 : int'(rest_s)) * 1000;
    endfunction

    function int unsigned stop_delay_ms();
      return ((stby_s == 0) ? 5 : int'(stby_s)) * 1000;
    endfunction

    function int unsigned limit_ckph();
      return ((limit_kph == 0) ? 1 : int'(limit_kph)) * 100;
    endfunction

    // a clock running backwards counts as no time spent
    function bit lasted_over(logic [TimeW-1:0] now, logic [TimeW-1:0] since,
                             int unsigned span_ms);
      return (now >= since) && ((now - since) > span_ms);
    endfunction

    function void take_sample(sample_t s);
      bit          moving;
      bit          closed;
      period_rec_t rec;
      moving = s.speed_ckph > limit_ckph();
      closed = 1'b0;
      if (s.cadence_rpm == 0 && moving && !coast_held) begin
        coast_held = 1'b1;
        coast_t0   = s.time_ms;
        coast_d0   = s.distance_m;
      end
      if (!moving && !stop_held) begin
        stop_held = 1'b1;
        stop_t0   = s.time_ms;
        stop_d0   = s.distance_m;
      end
      if (moving && stop_held && lasted_over(s.time_ms, stop_t0, stop_delay_ms())) begin
        rec.kind                  = KIND_STOP;
        rec.span.start_time_ms    = stop_t0;
        rec.span.start_distance_m = stop_d0;
        closed = 1'b1;
      end else if (s.cadence_rpm != 0 && moving && coast_held &&
                   lasted_over(s.time_ms, coast_t0, coast_delay_ms())) begin
        rec.kind                  = KIND_COAST;
        rec.span.start_time_ms    = coast_t0;
        rec.span.start_distance_m = coast_d0;
        closed = 1'b1;
      end
      if (closed) begin
        rec.span.end_time_ms    = s.time_ms;
        rec.span.end_distance_m = s.distance_m;
        pending_periods.push_back(rec);
      end
      if (s.cadence_rpm != 0 || !moving) coast_held = 1'b0;
      if (moving) stop_held = 1'b0;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task match_period(period_kind_e kind, period_t got);
      period_rec_t want;
      if (pending_periods.size() == 0) begin
        report_mismatch($sformatf("unexpected period kind %0d start %0d end %0d",
                                  kind, got.start_time_ms, got.end_time_ms));
        return;
      end
      want = pending_periods.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
      if (got.start_time_ms !== want.span.start_time_ms)
        report_mismatch($sformatf("start_time_ms %0d, want %0d",
                                  got.start_time_ms, want.span.start_time_ms));
      if (got.start_distance_m !== want.span.start_distance_m)
        report_mismatch($sformatf("start_distance_m %0d, want %0d",
                                  got.start_distance_m, want.span.start_distance_m));
      if (got.end_time_ms !== want.span.end_time_ms)
        report_mismatch($sformatf("end_time_ms %0d, want %0d",
                                  got.end_time_ms, want.span.end_time_ms));
      if (got.end_distance_m !== want.span.end_distance_m)
        report_mismatch($sformatf("end_distance_m %0d, want %0d",
                                  got.end_distance_m, want.span.end_distance_m));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  cfg_reg_e              cfg_index_i = REG_REST_DELAY;
  logic [CfgDataW-1:0]   cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  m_axis_tuser;

  ride_period_model rides;
  sample_t          opening_samples[$];
  bit               hold_off_req = 1'b0;
  int unsigned      idle_cycles = 0;

  ride_mode_e       ride_mode = RIDE_STOPPED;
  int unsigned      seg_left = 0;
  logic [TimeW-1:0] ride_t = '0;
  logic [DistW-1:0] ride_d = '0;

  coast_and_stop_period_detector i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic sample_t ride_point(logic [TimeW-1:0] t, logic [DistW-1:0] d,
                                         logic [CadW-1:0] c, logic [SpdW-1:0] v);
    sample_t s;
    s.time_ms     = t;
    s.distance_m  = d;
    s.cadence_rpm = c;
    s.speed_ckph  = v;
    return s;
  endfunction

  // Segments of stopping, coasting and pedalling with a little noise mixed in.
  function automatic sample_t next_ride_sample();
    sample_t     s;
    int unsigned lim;
    int unsigned top;
    lim = rides.limit_ckph();
    if ($urandom_range(0, 11) == 0) begin
      s.time_ms     = $urandom;
      s.distance_m  = $urandom;
      s.cadence_rpm = CadW'($urandom);
      s.speed_ckph  = SpdW'($urandom);
      return s;
    end
    if (seg_left == 0) begin
      ride_mode = ride_mode_e'($urandom_range(0, 2));
      seg_left  = $urandom_range(1, 10);
    end
    seg_left--;
    case ($urandom_range(0, 19))
      0:       ride_t = ride_t - $urandom_range(1, 20000);
      1:       ride_t = $urandom;
      2:       ;
      default: ride_t = ride_t + $urandom_range(1, 9000);
    endcase
    ride_d = ($urandom_range(0, 49) == 0) ? $urandom : ride_d + $urandom_range(0, 250);
    s.time_ms    = ride_t;
    s.distance_m = ride_d;
    top = ($urandom_range(0, 7) == 0) ? 65535 : lim + 4000;
    case (ride_mode)
      RIDE_STOPPED: begin
        s.speed_ckph  = SpdW'($urandom_range(0, lim));
        s.cadence_rpm = $urandom_range(0, 1) ? '0 : CadW'($urandom_range(1, 255));
      end
      RIDE_COASTING: begin
        s.speed_ckph  = SpdW'($urandom_range(lim + 1, top));
        s.cadence_rpm = '0;
      end
      default: begin
        s.speed_ckph  = SpdW'($urandom_range(lim + 1, top));
        s.cadence_rpm = CadW'($urandom_range(1, 255));
      end
    endcase
    // now and then land one ms around the delay edge
    if (ride_mode != RIDE_STOPPED && $urandom_range(0, 5) == 0) begin
      if (rides.stop_held)
        s.time_ms = rides.stop_t0 + rides.stop_delay_ms() - 1 + $urandom_range(0, 2);
      else if (ride_mode == RIDE_PEDALLING && rides.coast_held)
        s.time_ms = rides.coast_t0 + rides.coast_delay_ms() - 1 + $urandom_range(0, 2);
      ride_t = s.time_ms;
    end
    return s;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    rides.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(logic [CfgDataW-1:0] rest, logic [CfgDataW-1:0] stby,
                           logic [CfgDataW-1:0] lim);
    write_reg(REG_REST_DELAY, rest);
    write_reg(REG_STANDBY_DELAY, stby);
    write_reg(REG_STANDBY_LIMIT, lim);
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_sample(sample_t s);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    rides.take_sample(s);
    @(negedge clk_i);
  endtask

  task automatic run_phase(int unsigned n, bit gaps);
    int unsigned burst;
    sample_t     s;
    burst = $urandom_range(1, 40);
    for (int unsigned i = 0; i < n; i++) begin
      s = (opening_samples.size() != 0) ? opening_samples.pop_front() : next_ride_sample();
      send_sample(s);
      burst--;
      if (burst == 0) begin
        if (gaps) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(negedge clk_i);
        end
        burst = $urandom_range(1, 40);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (rides.pending_periods.size() != 0) @(negedge clk_i);
    // samples that close nothing may still be in the pipeline
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    rides = new();
    // reset defaults: 10 s rest, 5 s standby, 1 km/h limit
    opening_samples.push_back(ride_point(32'd0, 32'd0, 8'd0, 16'd0));  // stop from time zero
    opening_samples.push_back(ride_point(32'd5000, 32'd10, 8'd0, 16'd100));  // at limit
    opening_samples.push_back(ride_point(32'd5001, 32'd20, 8'd90, 16'd101));  // just over delay
    opening_samples.push_back(ride_point(32'd6000, 32'd30, 8'd0, 16'hFFFF));
    opening_samples.push_back(ride_point(32'd16000, 32'd40, 8'd0, 16'd2000));
    opening_samples.push_back(ride_point(32'd16000, 32'd50, 8'd255, 16'd3000));  // exactly delay
    opening_samples.push_back(ride_point(32'd17000, 32'd60, 8'd0, 16'd3000));
    opening_samples.push_back(ride_point(32'd27001, 32'd70, 8'd1, 16'd3000));
    opening_samples.push_back(ride_point(32'd30000, 32'd80, 8'd0, 16'd0));
    opening_samples.push_back(ride_point(32'd1000, 32'd90, 8'd0, 16'd500));  // clock back
    opening_samples.push_back(ride_point(32'd500, 32'd95, 8'd7, 16'd500));
    opening_samples.push_back(ride_point(32'hFFFF_FF9B, 32'hFFFF_FFF0, 8'd0, 16'd0));
    opening_samples.push_back(ride_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 16'hFFFF));
    opening_samples.push_back(ride_point(32'd0, 32'd0, 8'd40, 16'd0));
    opening_samples.push_back(ride_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 16'hFFFF));
    opening_samples.push_back(ride_point(32'hFFFF_FFFF, 32'd0, 8'd200, 16'd300));
    opening_samples.push_back(ride_point(32'hAAAA_AAAA, 32'h5555_5555, 8'h55, 16'h5555));
    opening_samples.push_back(ride_point(32'h5555_5555, 32'hAAAA_AAAA, 8'hAA, 16'hAAAA));
    opening_samples.push_back(ride_point(32'h5555_5555, 32'hAAAA_AAAB, 8'h00, 16'd1));
    opening_samples.push_back(ride_point(32'hAAAA_AAAA, 32'h0000_0001, 8'h00, 16'hFFFF));
    opening_samples.push_back(ride_point(32'hAAAA_AAAB, 32'h0000_0002, 8'h01, 16'd101));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    run_phase(opening_samples.size(), 1'b1);

    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: configure(6'd1, 6'd1, 6'd15);
        1: configure(6'd63, 6'd63, 6'd1);
        2: configure(6'd50, 6'd50, 6'd10);
        3: configure(6'd0, 6'd0, 6'd0);
        default: configure(CfgDataW'($urandom_range(0, 63)), CfgDataW'($urandom_range(0, 63)),
                           ($urandom_range(0, 7) == 0) ? CfgDataW'($urandom_range(0, 63))
                                                      : CfgDataW'($urandom_range(0, 15)));
      endcase
      if (p == 2) hold_off_req = 1'b1;
      run_phase(ItemsPerPhase, !(p == 2 || p == 5));
    end

    if (rides.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // receiver: changing stall styles, plus one long hold-off on request
  initial begin
    int unsigned stretch;
    int unsigned style;
    int unsigned tick;
    stretch = 0;
    style   = 0;
    tick    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      if (stretch == 0) begin
        style   = $urandom_range(0, 3);
        stretch = $urandom_range(16, 160);
      end
      stretch--;
      tick++;
      case (style)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= (tick % 4) != 3;
        default: m_axis_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      rides.match_period(period_kind_e'(m_axis_tuser), period_t'(m_axis_tdata));
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
